// ===== hw/rtl/pma_pkg.sv =====
// Shared constants, types and helpers for the prime modular ALU.
`default_nettype none

package pma_pkg;

    localparam int FuncW     = 3;
    localparam int OpndW     = 31;
    localparam int ResW      = 30;
    localparam int ProdW     = 2 * ResW;
    localparam int QW        = ProdW - (ResW - 1);
    localparam int QmuW      = 2 * QW;
    localparam int RemW      = ResW + 2;
    localparam int InTdataW  = 64;
    localparam int InTuserW  = FuncW;
    localparam int OutTdataW = 32;

    localparam logic [ResW-1:0]  Prime     = 30'd1000000007;
    localparam logic [ResW-1:0]  One       = 30'd1;
    localparam logic [OpndW-1:0] PrimeX1   = 31'(Prime);
    localparam logic [OpndW-1:0] PrimeX2   = {Prime, 1'b0};
    localparam logic [OpndW-1:0] InvExp    = PrimeX1 - 31'd2;
    localparam logic [63:0]      MuFull    = (64'd1 << ProdW) / 64'(Prime);
    localparam logic [QW-1:0]    BarrettMu = MuFull[QW-1:0];

    typedef enum logic [FuncW-1:0] {
        FN_ADD = 3'd0,
        FN_MUL = 3'd1,
        FN_POW = 3'd2,
        FN_INV = 3'd3,
        FN_DIV = 3'd4
    } t_func;

    typedef enum logic [2:0] {
        ISS_NONE,
        ISS_AB,
        ISS_ACC_SQ,
        ISS_SQ_SQ,
        ISS_ACC_A
    } t_iss;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_MUL,
        ST_POW_TEST,
        ST_ISS_ACC,
        ST_ISS_SQ,
        ST_DRAIN,
        ST_DIV,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic add;
        t_iss iss;
        logic shift;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic exp_zero;
        logic exp_lsb;
        logic mul_busy;
        logic out_free;
    } t_sts;

    function automatic logic [ResW-1:0] reduce_opnd(input logic [OpndW-1:0] v);
        logic [OpndW-1:0] d;
        priority if (v >= PrimeX2) begin
            d = v - PrimeX2;
        end else if (v >= PrimeX1) begin
            d = v - PrimeX1;
        end else begin
            d = v;
        end
        return d[ResW-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pma_modmul.sv =====
// Pipelined modular multiplier with Barrett reduction.
`default_nettype none

module pma_modmul (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_tag,
    input  logic [pma_pkg::ResW-1:0]  i_x,
    input  logic [pma_pkg::ResW-1:0]  i_y,
    output logic                      o_valid,
    output logic                      o_tag,
    output logic [pma_pkg::ResW-1:0]  o_res,
    output logic                      o_busy
);
    import pma_pkg::*;

    logic [2:0]       r_vld;
    logic [2:0]       n_vld;
    logic [2:0]       r_tag;
    logic [ProdW-1:0] r_prod;
    logic [QmuW-1:0]  r_qmu;
    logic [RemW-1:0]  r_lo2;
    logic [RemW-1:0]  r_lo3;
    logic [RemW-1:0]  r_qp_lo;
    logic [QW-1:0]    w_q1;
    logic [ResW-1:0]  w_q;
    logic [ProdW-1:0] w_qp;
    logic [RemW-1:0]  w_rem;
    logic [RemW-1:0]  w_fix;

    assign n_vld = {r_vld[1:0], i_valid};
    assign w_q1  = r_prod[ProdW-1:ResW-1];
    assign w_q   = r_qmu[2*ResW:ResW+1];
    assign w_qp  = ProdW'(w_q) * ProdW'(Prime);
    assign w_rem = r_lo3 - r_qp_lo;

    always_comb begin
        priority if (w_rem >= RemW'(PrimeX2)) begin
            w_fix = w_rem - RemW'(PrimeX2);
        end else if (w_rem >= RemW'(Prime)) begin
            w_fix = w_rem - RemW'(Prime);
        end else begin
            w_fix = w_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag   <= {r_tag[1:0], i_tag};
        r_prod  <= ProdW'(i_x) * ProdW'(i_y);
        r_qmu   <= QmuW'(w_q1) * QmuW'(BarrettMu);
        r_lo2   <= r_prod[RemW-1:0];
        r_lo3   <= r_lo2;
        r_qp_lo <= w_qp[RemW-1:0];
    end

    assign o_valid = r_vld[2];
    assign o_tag   = r_tag[2];
    assign o_res   = w_fix[ResW-1:0];
    assign o_busy  = |r_vld;

endmodule

`default_nettype wire

// ===== hw/rtl/pma_datapath.sv =====
// Datapath: operand registers, accumulator, square, exponent and result register.
`default_nettype none

module pma_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pma_pkg::t_cmd             i_cmd,
    input  logic [pma_pkg::FuncW-1:0] i_func,
    input  logic [pma_pkg::OpndW-1:0] i_opnd_a,
    input  logic [pma_pkg::OpndW-1:0] i_opnd_b,
    input  logic                      i_res_ready,
    output logic                      o_res_valid,
    output logic [pma_pkg::ResW-1:0]  o_res,
    output pma_pkg::t_sts             o_sts
);
    import pma_pkg::*;

    logic [ResW-1:0]  r_opa;
    logic [ResW-1:0]  r_opb;
    logic [ResW-1:0]  r_acc;
    logic [ResW-1:0]  n_acc;
    logic [ResW-1:0]  r_sq;
    logic [ResW-1:0]  n_sq;
    logic [OpndW-1:0] r_exp;
    logic [OpndW-1:0] n_exp;
    logic [ResW-1:0]  r_out;
    logic             r_out_vld;
    logic [ResW-1:0]  w_red_a;
    logic [ResW-1:0]  w_red_b;
    logic [ResW:0]    w_sum;
    logic [ResW-1:0]  w_add;
    logic             w_mul_in_vld;
    logic             w_mul_in_tag;
    logic [ResW-1:0]  w_mul_x;
    logic [ResW-1:0]  w_mul_y;
    logic             w_mul_vld;
    logic             w_mul_tag;
    logic [ResW-1:0]  w_mul_res;
    logic             w_mul_busy;

    assign w_red_a = reduce_opnd(i_opnd_a);
    assign w_red_b = reduce_opnd(i_opnd_b);
    assign w_sum   = {1'b0, r_opa} + {1'b0, r_opb};
    assign w_add   = (w_sum >= (ResW+1)'(Prime)) ? ResW'(w_sum - (ResW+1)'(Prime))
                                                 : w_sum[ResW-1:0];

    always_comb begin
        w_mul_in_vld = 1'b1;
        w_mul_in_tag = 1'b0;
        w_mul_x      = r_acc;
        w_mul_y      = r_sq;
        unique case (i_cmd.iss)
            ISS_AB: begin
                w_mul_x = r_opa;
                w_mul_y = r_opb;
            end
            ISS_ACC_SQ: begin
                w_mul_x = r_acc;
                w_mul_y = r_sq;
            end
            ISS_SQ_SQ: begin
                w_mul_x      = r_sq;
                w_mul_y      = r_sq;
                w_mul_in_tag = 1'b1;
            end
            ISS_ACC_A: begin
                w_mul_x = r_acc;
                w_mul_y = r_opa;
            end
            default: begin
                w_mul_in_vld = 1'b0;
            end
        endcase
    end

    pma_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mul_in_vld),
        .i_tag   (w_mul_in_tag),
        .i_x     (w_mul_x),
        .i_y     (w_mul_y),
        .o_valid (w_mul_vld),
        .o_tag   (w_mul_tag),
        .o_res   (w_mul_res),
        .o_busy  (w_mul_busy)
    );

    always_comb begin
        n_acc = r_acc;
        n_sq  = r_sq;
        n_exp = r_exp;
        if (i_cmd.load) begin
            unique case (t_func'(i_func))
                FN_POW: begin
                    n_sq  = w_red_a;
                    n_exp = i_opnd_b;
                    n_acc = One;
                end
                FN_INV: begin
                    n_sq  = w_red_a;
                    n_exp = InvExp;
                    n_acc = One;
                end
                FN_DIV: begin
                    n_sq  = w_red_b;
                    n_exp = InvExp;
                    n_acc = One;
                end
                default: begin
                    n_sq  = w_red_a;
                    n_exp = '0;
                    n_acc = '0;
                end
            endcase
        end else begin
            if (i_cmd.add) begin
                n_acc = w_add;
            end
            if (i_cmd.shift) begin
                n_exp = r_exp >> 1;
            end
            if (w_mul_vld) begin
                if (w_mul_tag) begin
                    n_sq = w_mul_res;
                end else begin
                    n_acc = w_mul_res;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_opa <= w_red_a;
            r_opb <= w_red_b;
        end
        r_acc <= n_acc;
        r_sq  <= n_sq;
        r_exp <= n_exp;
        if (i_cmd.out_load) begin
            r_out <= r_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_res_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_res_valid     = r_out_vld;
    assign o_res           = r_out;
    assign o_sts.exp_zero  = (r_exp == '0);
    assign o_sts.exp_lsb   = r_exp[0];
    assign o_sts.mul_busy  = w_mul_busy;
    assign o_sts.out_free  = !r_out_vld || i_res_ready;

endmodule

`default_nettype wire

// ===== hw/rtl/pma_ctrl.sv =====
// Controller state machine sequencing add, multiply and square-and-multiply.
`default_nettype none

module pma_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [pma_pkg::FuncW-1:0] i_func,
    input  pma_pkg::t_sts             i_sts,
    output logic                      o_in_ready,
    output pma_pkg::t_cmd             o_cmd
);
    import pma_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_div;
    logic   n_div;

    always_comb begin
        n_state = r_state;
        n_div   = r_div;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_div = (t_func'(i_func) == FN_DIV);
                    unique case (t_func'(i_func))
                        FN_ADD: n_state = ST_ADD;
                        FN_MUL: n_state = ST_MUL;
                        FN_POW, FN_INV, FN_DIV: n_state = ST_POW_TEST;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_ADD: n_state = ST_DONE;
            ST_MUL: n_state = ST_WAIT;
            ST_POW_TEST: begin
                if (i_sts.exp_zero) begin
                    n_state = r_div ? ST_DIV : ST_DONE;
                end else begin
                    n_state = ST_ISS_ACC;
                end
            end
            ST_ISS_ACC: n_state = ST_ISS_SQ;
            ST_ISS_SQ: n_state = ST_DRAIN;
            ST_DRAIN: begin
                priority if (i_sts.mul_busy) begin
                    n_state = ST_DRAIN;
                end else if (i_sts.exp_zero) begin
                    n_state = r_div ? ST_DIV : ST_DONE;
                end else begin
                    n_state = ST_ISS_ACC;
                end
            end
            ST_DIV: n_state = ST_WAIT;
            ST_WAIT: begin
                if (!i_sts.mul_busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready     = 1'b0;
        o_cmd.load     = 1'b0;
        o_cmd.add      = 1'b0;
        o_cmd.iss      = ISS_NONE;
        o_cmd.shift    = 1'b0;
        o_cmd.out_load = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_ADD: o_cmd.add = 1'b1;
            ST_MUL: o_cmd.iss = ISS_AB;
            ST_ISS_ACC: o_cmd.iss = i_sts.exp_lsb ? ISS_ACC_SQ : ISS_NONE;
            ST_ISS_SQ: begin
                o_cmd.iss   = ISS_SQ_SQ;
                o_cmd.shift = 1'b1;
            end
            ST_DIV: o_cmd.iss = ISS_ACC_A;
            ST_DONE: o_cmd.out_load = i_sts.out_free;
            default: begin
                o_cmd.iss = ISS_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_div   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_div   <= n_div;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/prime_modular_alu.sv =====
// Top level of the prime modular ALU: stream ports, controller and datapath.
//
// Modular arithmetic over the prime 1000000007, one transaction in and one
// result out. The unit takes one transaction at a time; a finished result
// sits in an output register, so the next transaction is taken while it waits.
// All products go through one three-stage Barrett modular multiplier. Power
// with exponent b works through b one bit at a time: each exponent bit issues
// a multiply if the bit is set, then a square, into the multiplier and then
// waits for it to drain; inverse and divide run the same loop with exponent
// p - 2, and divide then multiplies the result by operand a.
`default_nettype none

module prime_modular_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [30:0] operand_a, [61:31] operand_b, [63:62] zero
    input  logic [pma_pkg::InTdataW-1:0]  s_axis_tdata,
    // [2:0] func
    input  logic [pma_pkg::InTuserW-1:0]  s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [29:0] residue, [31:30] zero
    output logic [pma_pkg::OutTdataW-1:0] m_axis_tdata
);
    import pma_pkg::*;

    t_cmd            w_cmd;
    t_sts            w_sts;
    logic [ResW-1:0] w_res;

    pma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_func     (s_axis_tuser[FuncW-1:0]),
        .i_sts      (w_sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    pma_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_func      (s_axis_tuser[FuncW-1:0]),
        .i_opnd_a    (s_axis_tdata[OpndW-1:0]),
        .i_opnd_b    (s_axis_tdata[2*OpndW-1:OpndW]),
        .i_res_ready (m_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .o_sts       (w_sts)
    );

    assign m_axis_tdata = {{(OutTdataW-ResW){1'b0}}, w_res};

    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("transaction taken while another is in progress");

    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[ResW-1:0] < Prime))
        else $error("residue not reduced");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result register overwritten");

    a_load_idle_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> !w_sts.mul_busy)
        else $error("load while multiplier busy");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Stream testbench for the prime modular ALU: queued stimulus, own residue predictor, checks.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    localparam longint unsigned Modulus     = 64'(Prime);
    localparam logic [FuncW-1:0] FnRsvdLo   = 3'd5;
    localparam logic [FuncW-1:0] FnRsvdMid  = 3'd6;
    localparam logic [FuncW-1:0] FnRsvdHi   = 3'd7;
    localparam logic [OpndW-1:0] OpndMax    = '1;
    localparam int               RandItems  = 826;
    localparam int               HoldAt     = 300;
    localparam int               HoldCycles = 700;
    localparam int               DrainCycles = 250;
    localparam int               LimitCycles = 1_000_000;

    typedef struct packed {
        logic [FuncW-1:0] func;
        logic [OpndW-1:0] opa;
        logic [OpndW-1:0] opb;
    } t_alu_req;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [30:0] operand_a, [61:31] operand_b, [63:62] zero
    logic [InTdataW-1:0]  s_axis_tdata  = '0;
    // [2:0] func
    logic [InTuserW-1:0]  s_axis_tuser  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [29:0] residue, [31:30] zero
    logic [OutTdataW-1:0] m_axis_tdata;

    t_alu_req         req_q[$];
    logic [ResW-1:0]  residue_q[$];
    t_alu_req         tx_req;
    int               n_items      = 0;
    int               accepted_cnt = 0;
    int               tx_pop_cnt   = 0;
    int               tx_gap       = 0;
    bit               tx_burst     = 1'b0;
    int               rx_cnt       = 0;
    int               rx_wait      = 0;
    bit               rx_burst     = 1'b0;
    int               hold_left    = 0;
    bit               hold_armed   = 1'b1;
    int               fail_cnt     = 0;
    int               mismatch_cnt = 0;
    int               cycle_cnt    = 0;

    prime_modular_alu u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic longint unsigned mod_power(longint unsigned base, longint unsigned ex);
        longint unsigned acc = 1;
        longint unsigned sq  = base % Modulus;
        while (ex != 0) begin
            if ((ex & 1) != 0) acc = (acc * sq) % Modulus;
            sq = (sq * sq) % Modulus;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic [ResW-1:0] predict_residue(logic [FuncW-1:0] func,
                                                        logic [OpndW-1:0] opa,
                                                        logic [OpndW-1:0] opb);
        longint unsigned a = 64'(opa);
        longint unsigned b = 64'(opb);
        longint unsigned r;
        case (func)
            FN_ADD:  r = (a % Modulus + b % Modulus) % Modulus;
            FN_MUL:  r = (a * b) % Modulus;
            FN_POW:  r = mod_power(a, b);
            FN_INV:  r = mod_power(a, 64'(InvExp));
            FN_DIV:  r = ((a % Modulus) * mod_power(b, 64'(InvExp))) % Modulus;
            default: r = 0;
        endcase
        return r[ResW-1:0];
    endfunction

    function automatic logic [OpndW-1:0] rand_operand();
        logic [OpndW-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = 31'd1;
            2:       v = PrimeX1 - 31'd1 - OpndW'($urandom_range(0, 2));
            3:       v = PrimeX1 + OpndW'($urandom_range(0, 2));
            4:       v = PrimeX2 - 31'd1 + OpndW'($urandom_range(0, 2));
            5:       v = OpndMax - OpndW'($urandom_range(0, 3));
            default: v = OpndW'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [OpndW-1:0] rand_exponent();
        int len = $urandom_range(0, OpndW);
        return OpndW'($urandom) >> (OpndW - len);
    endfunction

    task automatic add_req(logic [FuncW-1:0] func, logic [OpndW-1:0] opa, logic [OpndW-1:0] opb);
        t_alu_req r;
        r.func = func;
        r.opa  = opa;
        r.opb  = opb;
        req_q.push_back(r);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                residue_q.push_back(predict_residue(s_axis_tuser, s_axis_tdata[OpndW-1:0],
                                                    s_axis_tdata[2*OpndW-1:OpndW]));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end else if (req_q.size() != 0) begin
                    tx_req = req_q.pop_front();
                    if (tx_pop_cnt % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
                    tx_pop_cnt    = tx_pop_cnt + 1;
                    s_axis_tuser  <= tx_req.func;
                    s_axis_tdata  <= {2'b00, tx_req.opb, tx_req.opa};
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= tx_burst ? 0 : $urandom_range(0, 5);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left  <= 0;
            hold_armed <= 1'b1;
        end else if (hold_armed && accepted_cnt == HoldAt) begin
            hold_left  <= HoldCycles;
            hold_armed <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (residue_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected result: residue %0d", m_axis_tdata[ResW-1:0]);
                    fail_cnt = fail_cnt + 1;
                end else if (m_axis_tdata[ResW-1:0] !== residue_q[0]) begin
                    if (mismatch_cnt < 10)
                        $display("residue mismatch: expected %0d, got %0d",
                                 residue_q[0], m_axis_tdata[ResW-1:0]);
                    mismatch_cnt = mismatch_cnt + 1;
                    fail_cnt     = fail_cnt + 1;
                    void'(residue_q.pop_front());
                end else begin
                    void'(residue_q.pop_front());
                end
                if (rx_cnt % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
                rx_cnt  = rx_cnt + 1;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 5);
            end else if (rx_wait != 0) begin
                rx_wait = rx_wait - 1;
            end
            m_axis_tready <= (rx_wait == 0) && (hold_left == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LimitCycles) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_alu_req r;
        int       pick;

        add_req(FN_ADD, '0, '0);
        add_req(FN_ADD, OpndMax, OpndMax);
        add_req(FN_ADD, PrimeX1, 31'd1);
        add_req(FN_MUL, OpndMax, OpndMax);
        add_req(FN_MUL, PrimeX1 - 31'd1, PrimeX1 - 31'd1);
        add_req(FN_MUL, '0, OpndMax);
        add_req(FN_POW, '0, '0);
        add_req(FN_POW, 31'd5, '0);
        add_req(FN_POW, OpndMax, OpndMax);
        add_req(FN_POW, PrimeX1, 31'd3);
        add_req(FN_POW, 31'd2, PrimeX1 - 31'd1);
        add_req(FN_POW, 31'd3, OpndMax);
        add_req(FN_INV, '0, '0);
        add_req(FN_INV, PrimeX1, 31'd9);
        add_req(FN_INV, PrimeX2, '0);
        add_req(FN_INV, 31'd1, '0);
        add_req(FN_INV, OpndMax, OpndMax);
        add_req(FN_DIV, 31'd7, '0);
        add_req(FN_DIV, 31'd7, PrimeX1);
        add_req(FN_DIV, OpndMax, OpndMax);
        add_req(FN_DIV, '0, 31'd5);
        add_req(FnRsvdLo, OpndMax, OpndMax);
        add_req(FnRsvdMid, 31'd12345, 31'd678);
        add_req(FnRsvdHi, OpndMax, OpndMax);

        for (int i = 0; i < RandItems; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 18) r.func = FuncW'(pick % 5);
            else r.func = FnRsvdLo + FuncW'($urandom_range(0, 2));
            r.opa = ($urandom_range(0, 1) == 0) ? rand_operand() : OpndW'($urandom);
            if (r.func == FN_POW && $urandom_range(0, 1) == 0) r.opb = rand_exponent();
            else r.opb = ($urandom_range(0, 1) == 0) ? rand_operand() : OpndW'($urandom);
            req_q.push_back(r);
        end
        n_items = req_q.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (accepted_cnt != n_items || residue_q.size() != 0);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_cnt == 0 && residue_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
